>>> src/lstp_pkg.sv
// Shared definitions for the 3D line stepper: command codes, axis codes,
// result flag bundle and default coordinate width.
// No dependencies.
package lstp_pkg;

    // default coordinate width for the top level parameter
    localparam int COORD_WIDTH_DEF = 16;

    // command codes carried in the cmd field
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // bit positions in the direction vector
    localparam int DIR_X = 0;
    localparam int DIR_Y = 1;
    localparam int DIR_Z = 2;

    // dominant axis of the line in progress
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // per-result status flags
    typedef struct packed {
        logic last;
        logic idle;
    } flags_t;

endpackage

>>> src/lstp_delta.sv
// One axis of the load preparation: signed difference end - start,
// its magnitude and its sign. Depends on lstp_pkg.
module lstp_delta
    import lstp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic signed [COORD_WIDTH-1:0] start_c,
    input  logic signed [COORD_WIDTH-1:0] end_c,
    output logic        [COORD_WIDTH-1:0] abs_d,
    output logic                          neg_d
);

    logic signed [COORD_WIDTH:0] diff;
    logic signed [COORD_WIDTH:0] mag;

    // one bit of headroom so the difference never wraps
    assign diff  = {end_c[COORD_WIDTH-1], end_c} - {start_c[COORD_WIDTH-1], start_c};
    assign neg_d = diff[COORD_WIDTH];
    assign mag   = neg_d ? -diff : diff;
    // magnitude is at most 2^W - 1, fits the lower W bits
    assign abs_d = mag[COORD_WIDTH-1:0];

endmodule

>>> src/lstp_core.sv
// Line state and per-item update: axis selection and error seeding on
// load, one Bresenham step on step. Depends on lstp_pkg.
module lstp_core
    import lstp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          cmd,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] start_z,
    input  logic        [COORD_WIDTH-1:0] abs_x,
    input  logic        [COORD_WIDTH-1:0] abs_y,
    input  logic        [COORD_WIDTH-1:0] abs_z,
    input  logic        [2:0]             neg,
    output logic signed [COORD_WIDTH-1:0] point_x,
    output logic signed [COORD_WIDTH-1:0] point_y,
    output logic signed [COORD_WIDTH-1:0] point_z,
    output flags_t                        flags
);

    localparam int TW = COORD_WIDTH + 1;   // doubled delta
    localparam int EW = COORD_WIDTH + 3;   // error term, signed

    // state
    logic signed [COORD_WIDTH-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic signed [COORD_WIDTH-1:0] cur_x_next, cur_y_next, cur_z_next;
    logic signed [EW-1:0]          err_first_reg, err_second_reg;
    logic signed [EW-1:0]          err_first_next, err_second_next;
    logic        [TW-1:0]          twice_dx_reg, twice_dy_reg, twice_dz_reg;
    logic        [TW-1:0]          twice_dx_next, twice_dy_next, twice_dz_next;
    axis_t                         axis_reg, axis_next;
    logic        [2:0]             dir_neg_reg, dir_neg_next;
    logic        [COORD_WIDTH-1:0] steps_left_reg, steps_left_next;
    logic                          busy_reg, busy_next;

    // load path
    logic                          x_major, y_ge_z;
    logic        [COORD_WIDTH-1:0] len_ld;
    logic        [TW-1:0]          tdx_ld, tdy_ld, tdz_ld;

    // step path
    logic                          ef_pos, es_pos;
    logic        [TW-1:0]          t_major, t_first, t_second;
    logic        [2:0]             mv;
    logic        [COORD_WIDTH-1:0] steps_dec;

    function automatic logic signed [EW-1:0] ext_w(input logic [COORD_WIDTH-1:0] v);
        ext_w = $signed({{(EW-COORD_WIDTH){1'b0}}, v});
    endfunction

    function automatic logic signed [EW-1:0] ext_t(input logic [TW-1:0] v);
        ext_t = $signed({{(EW-TW){1'b0}}, v});
    endfunction

    // move a coordinate one unit in its direction when asked
    function automatic logic signed [COORD_WIDTH-1:0] nudge(
        input logic signed [COORD_WIDTH-1:0] c,
        input logic                          go,
        input logic                          down
    );
        logic signed [COORD_WIDTH-1:0] r;
        r = c;
        if (go) begin
            r = down ? c - COORD_WIDTH'(1) : c + COORD_WIDTH'(1);
        end
        nudge = r;
    endfunction

    assign tdx_ld = {abs_x, 1'b0};
    assign tdy_ld = {abs_y, 1'b0};
    assign tdz_ld = {abs_z, 1'b0};
    // x wins ties, then y
    assign x_major = (abs_x >= abs_y) && (abs_x >= abs_z);
    assign y_ge_z  = (abs_y >= abs_z);

    assign ef_pos    = !err_first_reg[EW-1] && (|err_first_reg);
    assign es_pos    = !err_second_reg[EW-1] && (|err_second_reg);
    assign steps_dec = steps_left_reg - COORD_WIDTH'(1);

    // routing of deltas and move enables by major axis (mv: z,y,x)
    always_comb begin
        case (axis_reg)
            AXIS_Y: begin
                t_major  = twice_dy_reg;
                t_first  = twice_dx_reg;
                t_second = twice_dz_reg;
                mv       = {es_pos, 1'b1, ef_pos};
            end
            AXIS_Z: begin
                t_major  = twice_dz_reg;
                t_first  = twice_dy_reg;
                t_second = twice_dx_reg;
                mv       = {1'b1, ef_pos, es_pos};
            end
            default: begin
                t_major  = twice_dx_reg;
                t_first  = twice_dy_reg;
                t_second = twice_dz_reg;
                mv       = {es_pos, ef_pos, 1'b1};
            end
        endcase
    end

    // next state and result
    always_comb begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        cur_z_next      = cur_z_reg;
        err_first_next  = err_first_reg;
        err_second_next = err_second_reg;
        twice_dx_next   = twice_dx_reg;
        twice_dy_next   = twice_dy_reg;
        twice_dz_next   = twice_dz_reg;
        axis_next       = axis_reg;
        dir_neg_next    = dir_neg_reg;
        steps_left_next = steps_left_reg;
        busy_next       = busy_reg;
        len_ld          = abs_x;
        flags           = '0;

        if (cmd == CMD_LOAD) begin
            cur_x_next    = start_x;
            cur_y_next    = start_y;
            cur_z_next    = start_z;
            dir_neg_next  = neg;
            twice_dx_next = tdx_ld;
            twice_dy_next = tdy_ld;
            twice_dz_next = tdz_ld;
            if (x_major) begin
                axis_next       = AXIS_X;
                len_ld          = abs_x;
                err_first_next  = ext_t(tdy_ld) - ext_w(abs_x);
                err_second_next = ext_t(tdz_ld) - ext_w(abs_x);
            end else if (y_ge_z) begin
                axis_next       = AXIS_Y;
                len_ld          = abs_y;
                err_first_next  = ext_t(tdx_ld) - ext_w(abs_y);
                err_second_next = ext_t(tdz_ld) - ext_w(abs_y);
            end else begin
                axis_next       = AXIS_Z;
                len_ld          = abs_z;
                err_first_next  = ext_t(tdy_ld) - ext_w(abs_z);
                err_second_next = ext_t(tdx_ld) - ext_w(abs_z);
            end
            steps_left_next = len_ld;
            busy_next       = (len_ld != '0);
            flags.last      = (len_ld == '0);
        end else if (!busy_reg) begin
            // nothing in progress: hold point, flag idle
            flags.idle = 1'b1;
        end else begin
            cur_x_next      = nudge(cur_x_reg, mv[DIR_X], dir_neg_reg[DIR_X]);
            cur_y_next      = nudge(cur_y_reg, mv[DIR_Y], dir_neg_reg[DIR_Y]);
            cur_z_next      = nudge(cur_z_reg, mv[DIR_Z], dir_neg_reg[DIR_Z]);
            err_first_next  = err_first_reg - (ef_pos ? ext_t(t_major) : '0)
                              + ext_t(t_first);
            err_second_next = err_second_reg - (es_pos ? ext_t(t_major) : '0)
                              + ext_t(t_second);
            steps_left_next = steps_dec;
            busy_next       = (steps_dec != '0);
            flags.last      = (steps_dec == '0);
        end
    end

    assign point_x = cur_x_next;
    assign point_y = cur_y_next;
    assign point_z = cur_z_next;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            cur_z_reg      <= '0;
            err_first_reg  <= '0;
            err_second_reg <= '0;
            twice_dx_reg   <= '0;
            twice_dy_reg   <= '0;
            twice_dz_reg   <= '0;
            axis_reg       <= AXIS_X;
            dir_neg_reg    <= '0;
            steps_left_reg <= '0;
            busy_reg       <= 1'b0;
        end else if (en) begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            cur_z_reg      <= cur_z_next;
            err_first_reg  <= err_first_next;
            err_second_reg <= err_second_next;
            twice_dx_reg   <= twice_dx_next;
            twice_dy_reg   <= twice_dy_next;
            twice_dz_reg   <= twice_dz_next;
            axis_reg       <= axis_next;
            dir_neg_reg    <= dir_neg_next;
            steps_left_reg <= steps_left_next;
            busy_reg       <= busy_next;
        end
    end

endmodule

>>> src/line_stepper_3d.sv
// Top level of the 3D line stepper: input stage with delta preparation,
// step core and result register. Depends on lstp_pkg, lstp_delta, lstp_core.
//
// Usage:
//   Input channel (s_*): cmd = load carries a start and an end point; the
//   result is the start point, last set when the line has zero length.
//   cmd = step moves one point along the line in progress; its result is
//   the new point, last set on the end point. A step with no line in
//   progress returns the held point with idle set.
//   Result channel (m_*): exactly one transfer per input transfer, in order.
//   Path to m_valid: the input register, then the step core writing the
//   result register.
//   Throughput: one item per cycle while results are taken; the core's
//   state feeds back to itself, so back-to-back steps run at full rate.
//   Stall: when m_ready is low the result holds; the input register still
//   takes one more item, then s_ready drops until the result is taken.
//   Reset: aresetn low (synchronous) clears the line state (no line, point
//   at the origin), empties both stages and holds s_ready low.
module line_stepper_3d
    import lstp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic signed [COORD_WIDTH-1:0] s_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_start_z,
    input  logic signed [COORD_WIDTH-1:0] s_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_end_y,
    input  logic signed [COORD_WIDTH-1:0] s_end_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_point_x,
    output logic signed [COORD_WIDTH-1:0] m_point_y,
    output logic signed [COORD_WIDTH-1:0] m_point_z,
    output logic                          m_last,
    output logic                          m_idle
);

    // input stage
    logic                          p_valid_reg;
    logic                          p_cmd_reg;
    logic signed [COORD_WIDTH-1:0] p_start_x_reg, p_start_y_reg, p_start_z_reg;
    logic        [COORD_WIDTH-1:0] p_abs_x_reg, p_abs_y_reg, p_abs_z_reg;
    logic        [2:0]             p_neg_reg;

    // result stage
    logic                          m_valid_reg;
    logic signed [COORD_WIDTH-1:0] m_point_x_reg, m_point_y_reg, m_point_z_reg;
    flags_t                        m_flags_reg;

    logic                          s_xfer, adv;
    logic        [COORD_WIDTH-1:0] abs_x, abs_y, abs_z;
    logic        [2:0]             neg;
    logic signed [COORD_WIDTH-1:0] core_x, core_y, core_z;
    flags_t                        core_flags;

    // handshake: core fires when the result slot is free or being drained
    assign adv     = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = aresetn && (!p_valid_reg || adv);
    assign s_xfer  = s_valid && s_ready;

    // per-axis magnitude and sign of end - start
    lstp_delta #(.COORD_WIDTH(COORD_WIDTH)) u_delta_x (
        .start_c(s_start_x), .end_c(s_end_x), .abs_d(abs_x), .neg_d(neg[DIR_X])
    );
    lstp_delta #(.COORD_WIDTH(COORD_WIDTH)) u_delta_y (
        .start_c(s_start_y), .end_c(s_end_y), .abs_d(abs_y), .neg_d(neg[DIR_Y])
    );
    lstp_delta #(.COORD_WIDTH(COORD_WIDTH)) u_delta_z (
        .start_c(s_start_z), .end_c(s_end_z), .abs_d(abs_z), .neg_d(neg[DIR_Z])
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p_valid_reg <= s_valid;
        end
        if (s_xfer) begin
            p_cmd_reg     <= s_cmd;
            p_start_x_reg <= s_start_x;
            p_start_y_reg <= s_start_y;
            p_start_z_reg <= s_start_z;
            p_abs_x_reg   <= abs_x;
            p_abs_y_reg   <= abs_y;
            p_abs_z_reg   <= abs_z;
            p_neg_reg     <= neg;
        end
    end

    lstp_core #(.COORD_WIDTH(COORD_WIDTH)) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .cmd     (p_cmd_reg),
        .start_x (p_start_x_reg),
        .start_y (p_start_y_reg),
        .start_z (p_start_z_reg),
        .abs_x   (p_abs_x_reg),
        .abs_y   (p_abs_y_reg),
        .abs_z   (p_abs_z_reg),
        .neg     (p_neg_reg),
        .point_x (core_x),
        .point_y (core_y),
        .point_z (core_z),
        .flags   (core_flags)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (adv) begin
            m_point_x_reg <= core_x;
            m_point_y_reg <= core_y;
            m_point_z_reg <= core_z;
            m_flags_reg   <= core_flags;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_point_x = m_point_x_reg;
    assign m_point_y = m_point_y_reg;
    assign m_point_z = m_point_z_reg;
    assign m_last    = m_flags_reg.last;
    assign m_idle    = m_flags_reg.idle;

endmodule

>>> src/lstp_checker.sv
// Port-level checks for line_stepper_3d, bound to every instance.
// Depends on lstp_pkg and line_stepper_3d.
module lstp_checker
    import lstp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [COORD_WIDTH-1:0] m_point_x,
    input logic signed [COORD_WIDTH-1:0] m_point_y,
    input logic signed [COORD_WIDTH-1:0] m_point_z,
    input logic                          m_last,
    input logic                          m_idle
);

    // reset empties the result slot
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_x) && $stable(m_point_y)
        && $stable(m_point_z) && $stable(m_last) && $stable(m_idle))
        else $error("stalled result changed");

    // idle results never mark the end of a line
    a_idle_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_idle && m_last))
        else $error("result flagged both idle and last");

    // from an empty pipe a result follows a transfer through both registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching input transfer");

endmodule

bind line_stepper_3d lstp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lstp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_point_x (m_point_x),
    .m_point_y (m_point_y),
    .m_point_z (m_point_z),
    .m_last    (m_last),
    .m_idle    (m_idle)
);

>>> test/line_stepper_3d_test.sv
// Self-checking testbench for line_stepper_3d: directed rows, then random line sequences.
// Results are checked against a local Bresenham tracker.
// Depends on lstp_pkg and line_stepper_3d.
module line_stepper_3d_test;
    import lstp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int ITEM_TARGET = 1600;

    typedef logic signed [CW-1:0] coord_t;

    localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
        logic   idle;
    } point_t;

    typedef struct {
        logic   cmd;
        coord_t sx, sy, sz, ex, ey, ez;
        bit     known;
        point_t want;
    } plan_row_t;

    logic   aclk      = 1'b0;
    logic   aresetn   = 1'b0;
    logic   s_valid   = 1'b0;
    logic   s_cmd     = CMD_LOAD;
    coord_t s_start_x = '0;
    coord_t s_start_y = '0;
    coord_t s_start_z = '0;
    coord_t s_end_x   = '0;
    coord_t s_end_y   = '0;
    coord_t s_end_z   = '0;
    logic   m_ready   = 1'b1;
    logic   s_ready;
    logic   m_valid;
    coord_t m_point_x;
    coord_t m_point_y;
    coord_t m_point_z;
    logic   m_last;
    logic   m_idle;

    // tracker state: a copy of the line in progress
    coord_t     pos_x, pos_y, pos_z;
    int         err_a, err_b;
    int         twice_x, twice_y, twice_z;
    axis_t      major;
    logic [2:0] heads_negative;
    int         remaining;
    bit         tracing;

    point_t    point_queue[$];
    plan_row_t plan_rows[$];
    int        mismatches  = 0;
    int        sent        = 0;
    int        hold_cycles = 0;
    bit        tx_jitter   = 1'b1;
    bit        rx_jitter   = 1'b1;

    line_stepper_3d #(.COORD_WIDTH(CW)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_start_x (s_start_x),
        .s_start_y (s_start_y),
        .s_start_z (s_start_z),
        .s_end_x   (s_end_x),
        .s_end_y   (s_end_y),
        .s_end_z   (s_end_z),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_point_x (m_point_x),
        .m_point_y (m_point_y),
        .m_point_z (m_point_z),
        .m_last    (m_last),
        .m_idle    (m_idle)
    );

    always #5 aclk = ~aclk;

    // one unit step along an axis, toward the end point
    function automatic coord_t nudge(coord_t c, int axis_bit);
        return heads_negative[axis_bit] ? c - coord_t'(1) : c + coord_t'(1);
    endfunction

    // advance the tracked line by one transfer and return the point it yields
    function automatic point_t advance_trace(logic cmd, coord_t sx, coord_t sy, coord_t sz,
                                             coord_t ex, coord_t ey, coord_t ez);
        int dx, dy, dz, l, m, n, span;
        if (cmd == CMD_LOAD) begin
            dx = int'(ex) - int'(sx);
            dy = int'(ey) - int'(sy);
            dz = int'(ez) - int'(sz);
            l = (dx < 0) ? -dx : dx;
            m = (dy < 0) ? -dy : dy;
            n = (dz < 0) ? -dz : dz;
            pos_x = sx;
            pos_y = sy;
            pos_z = sz;
            heads_negative[DIR_X] = (dx < 0);
            heads_negative[DIR_Y] = (dy < 0);
            heads_negative[DIR_Z] = (dz < 0);
            twice_x = 2 * l;
            twice_y = 2 * m;
            twice_z = 2 * n;
            // x wins ties, then y
            if (l >= m && l >= n) begin
                major = AXIS_X;
                span  = l;
                err_a = twice_y - l;
                err_b = twice_z - l;
            end else if (m >= l && m >= n) begin
                major = AXIS_Y;
                span  = m;
                err_a = twice_x - m;
                err_b = twice_z - m;
            end else begin
                major = AXIS_Z;
                span  = n;
                err_a = twice_y - n;
                err_b = twice_x - n;
            end
            remaining = span;
            tracing   = (span != 0);
            return '{pos_x, pos_y, pos_z, span == 0, 1'b0};
        end
        // step with nothing in flight holds the point
        if (!tracing)
            return '{pos_x, pos_y, pos_z, 1'b0, 1'b1};
        case (major)
            AXIS_X: begin
                if (err_a > 0) begin pos_y = nudge(pos_y, DIR_Y); err_a -= twice_x; end
                if (err_b > 0) begin pos_z = nudge(pos_z, DIR_Z); err_b -= twice_x; end
                err_a += twice_y;
                err_b += twice_z;
                pos_x = nudge(pos_x, DIR_X);
            end
            AXIS_Y: begin
                if (err_a > 0) begin pos_x = nudge(pos_x, DIR_X); err_a -= twice_y; end
                if (err_b > 0) begin pos_z = nudge(pos_z, DIR_Z); err_b -= twice_y; end
                err_a += twice_x;
                err_b += twice_z;
                pos_y = nudge(pos_y, DIR_Y);
            end
            default: begin
                if (err_a > 0) begin pos_y = nudge(pos_y, DIR_Y); err_a -= twice_z; end
                if (err_b > 0) begin pos_x = nudge(pos_x, DIR_X); err_b -= twice_z; end
                err_a += twice_y;
                err_b += twice_x;
                pos_z = nudge(pos_z, DIR_Z);
            end
        endcase
        remaining--;
        tracing = (remaining != 0);
        return '{pos_x, pos_y, pos_z, !tracing, 1'b0};
    endfunction

    // directed table rows: predicted, or with the result typed in
    function automatic void plan_row(logic cmd, coord_t sx, coord_t sy, coord_t sz,
                                     coord_t ex, coord_t ey, coord_t ez);
        plan_row_t r;
        r.cmd = cmd;
        r.sx = sx; r.sy = sy; r.sz = sz;
        r.ex = ex; r.ey = ey; r.ez = ez;
        r.known = 1'b0;
        r.want = '{'0, '0, '0, 1'b0, 1'b0};
        plan_rows.insert(plan_rows.size(), r);
    endfunction

    function automatic void plan_known(logic cmd, coord_t sx, coord_t sy, coord_t sz,
                                       coord_t ex, coord_t ey, coord_t ez,
                                       coord_t wx, coord_t wy, coord_t wz,
                                       logic wlast, logic widle);
        plan_row(cmd, sx, sy, sz, ex, ey, ez);
        plan_rows[plan_rows.size()-1].known = 1'b1;
        plan_rows[plan_rows.size()-1].want = '{wx, wy, wz, wlast, widle};
    endfunction

    // stimulus helpers
    function automatic coord_t pick_coord();
        case ($urandom_range(0, 7))
            0: return CMIN;
            1: return CMAX;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic coord_t near_coord(coord_t base);
        int v;
        v = int'(base) + int'($urandom_range(0, 24)) - 12;
        if ($urandom_range(0, 3) == 0)
            v = int'(base);
        if (v > int'(CMAX))
            v = int'(CMAX);
        if (v < int'(CMIN))
            v = int'(CMIN);
        return coord_t'(v);
    endfunction

    function automatic int major_span(coord_t sx, coord_t sy, coord_t sz,
                                      coord_t ex, coord_t ey, coord_t ez);
        int dx, dy, dz, top;
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        dz = int'(ez) - int'(sz);
        top = (dx < 0) ? -dx : dx;
        if (((dy < 0) ? -dy : dy) > top) top = (dy < 0) ? -dy : dy;
        if (((dz < 0) ? -dz : dz) > top) top = (dz < 0) ? -dz : dz;
        return top;
    endfunction

    // offer one item, hold it until the transfer, then record its expected point
    task automatic send_item(logic cmd, coord_t sx, coord_t sy, coord_t sz,
                             coord_t ex, coord_t ey, coord_t ez);
        int gap;
        gap = (tx_jitter && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_start_x <= sx;
        s_start_y <= sy;
        s_start_z <= sz;
        s_end_x   <= ex;
        s_end_y   <= ey;
        s_end_z   <= ez;
        do @(posedge aclk); while (!s_ready);
        point_queue.insert(point_queue.size(), advance_trace(cmd, sx, sy, sz, ex, ey, ez));
        sent++;
    endtask

    task automatic send_step();
        send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    endtask

    // short well-formed line: load, then steps to the end, cut short or run past it
    task automatic random_line();
        coord_t sx, sy, sz, ex, ey, ez;
        int span, n, pick;
        sx = pick_coord();
        sy = pick_coord();
        sz = pick_coord();
        ex = near_coord(sx);
        ey = near_coord(sy);
        ez = near_coord(sz);
        span = major_span(sx, sy, sz, ex, ey, ez);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            n = $urandom_range(0, span);
        else if (pick <= 2)
            n = span + $urandom_range(1, 3);
        else
            n = span;
        send_item(CMD_LOAD, sx, sy, sz, ex, ey, ez);
        repeat (n) send_step();
    endtask

    // result side: random stalls and the long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
                m_ready <= 1'b1;
            end else if (rx_jitter && $urandom_range(0, 6) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // check every result transfer against the oldest expected point
    always @(posedge aclk) begin
        point_t want;
        if (aresetn && m_valid && m_ready) begin
            if (point_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected point (%0d,%0d,%0d) last=%b idle=%b",
                             m_point_x, m_point_y, m_point_z, m_last, m_idle);
            end else begin
                want = point_queue.pop_front();
                if (m_point_x !== want.x || m_point_y !== want.y || m_point_z !== want.z ||
                    m_last !== want.last || m_idle !== want.idle) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: expected (%0d,%0d,%0d) last=%b idle=%b, ",
                                  "got (%0d,%0d,%0d) last=%b idle=%b"},
                                 want.x, want.y, want.z, want.last, want.idle,
                                 m_point_x, m_point_y, m_point_z, m_last, m_idle);
                end
            end
        end
    end

    // main sequence
    initial begin
        bit squeezed, drained;
        int i;
        squeezed = 1'b0;
        drained  = 1'b0;
        pos_x = '0; pos_y = '0; pos_z = '0;
        err_a = 0; err_b = 0;
        twice_x = 0; twice_y = 0; twice_z = 0;
        major = AXIS_X;
        heads_negative = '0;
        remaining = 0;
        tracing = 1'b0;

        // step with no line after reset, zero-length line, extremes
        plan_known(CMD_STEP, 0, 0, 0, 0, 0, 0,  0, 0, 0, 1'b0, 1'b1);
        plan_known(CMD_LOAD, CMIN, CMAX, 0, CMIN, CMAX, 0,  CMIN, CMAX, 0, 1'b1, 1'b0);
        plan_known(CMD_STEP, 0, 0, 0, 0, 0, 0,  CMIN, CMAX, 0, 1'b0, 1'b1);
        plan_known(CMD_LOAD, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,  CMIN, CMIN, CMIN, 1'b0, 1'b0);
        plan_row(CMD_STEP, 0, 0, 0, 0, 0, 0);
        plan_known(CMD_LOAD, CMAX, CMAX, CMAX, CMIN, 0, CMAX,  CMAX, CMAX, CMAX, 1'b0, 1'b0);
        plan_row(CMD_STEP, 0, 0, 0, 0, 0, 0);
        // new line replaces the one in flight; y major, run to the end and past it
        plan_known(CMD_LOAD, 0, 0, 0, 1, 3, 2,  0, 0, 0, 1'b0, 1'b0);
        repeat (3) plan_row(CMD_STEP, 0, 0, 0, 0, 0, 0);
        plan_known(CMD_STEP, 0, 0, 0, 0, 0, 0,  1, 3, 2, 1'b0, 1'b1);
        // z major, all directions negative
        plan_known(CMD_LOAD, 5, 5, 5, 3, 4, 0,  5, 5, 5, 1'b0, 1'b0);
        repeat (5) plan_row(CMD_STEP, 0, 0, 0, 0, 0, 0);
        // y and z tie goes to y
        plan_known(CMD_LOAD, 0, 0, 0, 0, -2, -2,  0, 0, 0, 1'b0, 1'b0);
        repeat (2) plan_row(CMD_STEP, 0, 0, 0, 0, 0, 0);
        // three-way tie goes to x
        plan_known(CMD_LOAD, 10, -10, 7, 13, -7, 4,  10, -10, 7, 1'b0, 1'b0);
        repeat (3) plan_row(CMD_STEP, 0, 0, 0, 0, 0, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan_rows[k]) begin
            send_item(plan_rows[k].cmd, plan_rows[k].sx, plan_rows[k].sy, plan_rows[k].sz,
                      plan_rows[k].ex, plan_rows[k].ey, plan_rows[k].ez);
            if (plan_rows[k].known)
                point_queue[point_queue.size()-1] = plan_rows[k].want;
        end

        // random part
        while (sent < ITEM_TARGET) begin
            if (!squeezed && sent >= 500) begin
                // long result stall while a long line keeps the input busy
                squeezed = 1'b1;
                hold_cycles = 80;
                send_item(CMD_LOAD, 0, 0, 0, 40, 7, -3);
                for (i = 0; i < 40; i++)
                    send_step();
            end else if (!drained && sent >= 900) begin
                // sender pauses until everything has come back
                drained = 1'b1;
                s_valid <= 1'b0;
                while (point_queue.size() != 0) @(posedge aclk);
            end
            if (sent >= ITEM_TARGET - 300) begin
                tx_jitter = 1'b0;
                rx_jitter = 1'b0;
            end
            i = $urandom_range(0, 99);
            if (i < 70) begin
                random_line();
            end else if (i < 85) begin
                send_item(CMD_LOAD, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
                repeat ($urandom_range(0, 6)) send_step();
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item($urandom_range(0, 1) ? CMD_STEP : CMD_LOAD,
                              coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                              coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
            end
        end

        s_valid <= 1'b0;
        while (point_queue.size() != 0) @(posedge aclk);
        // let any stray transfer show up
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
